// ===== sv/amqpu_pkg.sv =====
// ----------------------------------------------------------------------------
// amqpu_pkg
// Shared types and constants for the AMQP URL stream parser.
// ----------------------------------------------------------------------------
package amqpu_pkg;

    localparam int BYTE_W    = 8;
    localparam int SEG_W     = 3;
    localparam int PORT_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_W   = 40;

    localparam logic [PORT_W-1:0]    PLAIN_PORT_RST = 16'd5672;
    localparam logic [PORT_W-1:0]    TLS_PORT_RST   = 16'd5671;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_PORT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TLS_PORT   = 1'b1;

    typedef struct packed {
        logic              char_valid;
        logic [BYTE_W-1:0] char_value;
        logic [SEG_W-1:0]  segment_tag;
        logic              done_res;
        logic              status;
        logic [PORT_W-1:0] port_number;
        logic              tls_scheme;
        logic              first_is_user;
        logic              second_present;
        logic              host_given;
        logic              vhost_given;
    } t_result;

endpackage

// ===== sv/amqpu_parse_core.sv =====
// ----------------------------------------------------------------------------
// amqpu_parse_core
// Parse state and combinational step logic: prefix check, escape decode,
// delimiter handling, port accumulation and the verdict on the end item.
// ----------------------------------------------------------------------------
module amqpu_parse_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [amqpu_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_end,
    input  logic [amqpu_pkg::PORT_W-1:0] i_plain_port,
    input  logic [amqpu_pkg::PORT_W-1:0] i_tls_port,
    output amqpu_pkg::t_result         o_res
);
    import amqpu_pkg::*;

    localparam logic [3:0] PH_PREFIX = 4'd0;
    localparam logic [3:0] PH_A      = 4'd1;
    localparam logic [3:0] PH_B      = 4'd2;
    localparam logic [3:0] PH_H      = 4'd3;
    localparam logic [3:0] PH_V6     = 4'd4;
    localparam logic [3:0] PH_AFTER  = 4'd5;
    localparam logic [3:0] PH_PORT   = 4'd6;
    localparam logic [3:0] PH_VHOST  = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;
    localparam logic [3:0] PH_ERR    = 4'd9;

    localparam logic [SEG_W-1:0] SEG_FIRST  = 3'd0;
    localparam logic [SEG_W-1:0] SEG_SECOND = 3'd1;
    localparam logic [SEG_W-1:0] SEG_HOST   = 3'd2;
    localparam logic [SEG_W-1:0] SEG_V6     = 3'd3;
    localparam logic [SEG_W-1:0] SEG_PORT   = 3'd4;
    localparam logic [SEG_W-1:0] SEG_VHOST  = 3'd5;

    localparam int RF_USER   = 0;
    localparam int RF_SECOND = 1;
    localparam int RF_HOST   = 2;
    localparam int RF_VHOST  = 3;

    localparam logic [16:0] PORT_SAT = 17'h10000;

    function automatic logic [7:0] pfx_char(input logic tls, input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = "a";
            3'd1:    c = "m";
            3'd2:    c = "q";
            3'd3:    c = "p";
            3'd4:    c = tls ? "s" : ":";
            3'd5:    c = tls ? ":" : "/";
            3'd6:    c = "/";
            default: c = tls ? "/" : 8'h00;
        endcase
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] h;
        if (b >= "0" && b <= "9")      h = {1'b1, b[3:0]};
        else if (b >= "a" && b <= "f") h = {1'b1, 4'(b - 8'h57)};
        else if (b >= "A" && b <= "F") h = {1'b1, 4'(b - 8'h37)};
        else                           h = 5'b0;
        return h;
    endfunction

    logic [3:0]        r_phase,    n_phase;
    logic [3:0]        r_pos,      n_pos;
    logic              r_tls,      n_tls;
    logic [1:0]        r_esc_cnt,  n_esc_cnt;
    logic [3:0]        r_esc_val,  n_esc_val;
    logic [SEG_W-1:0]  r_seg,      n_seg;
    logic              r_seg_ne,   n_seg_ne;
    logic [16:0]       r_acc,      n_acc;
    logic              r_port_ok,  n_port_ok;
    logic              r_port_giv, n_port_giv;
    logic [3:0]        r_flags,    n_flags;

    logic       do_delim;
    logic       do_data;
    logic [7:0] dval;
    logic [7:0] pexp;
    logic [4:0] hx;
    logic [7:0] esc_full;
    logic       is_dl;
    logic       port_bad;
    logic [19:0] acc_sum;
    logic [3:0] pos_inc;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_tls      = r_tls;
        n_esc_cnt  = r_esc_cnt;
        n_esc_val  = r_esc_val;
        n_seg      = r_seg;
        n_seg_ne   = r_seg_ne;
        n_acc      = r_acc;
        n_port_ok  = r_port_ok;
        n_port_giv = r_port_giv;
        n_flags    = r_flags;
        o_res      = '0;

        do_delim = 1'b0;
        do_data  = 1'b0;
        dval     = i_byte;
        pexp     = pfx_char(r_tls, r_pos[2:0]);
        hx       = hex_val(i_byte);
        esc_full = {r_esc_val, hx[3:0]};
        pos_inc  = r_pos + 4'd1;
        is_dl    = (i_byte == 8'h00) || (i_byte == "/") || (i_byte == "?") ||
                   (i_byte == "#") || (i_byte == "[") || (i_byte == "]") ||
                   ((r_phase != PH_V6) && ((i_byte == ":") || (i_byte == "@")));
        port_bad = r_port_giv && !(r_port_ok && !r_acc[16]);
        acc_sum  = {r_acc, 3'b0} + {2'b0, r_acc, 1'b0} + {16'b0, dval[3:0]};

        if (i_end) begin
            dval = 8'h00;
            if (r_phase == PH_PREFIX || r_esc_cnt != 2'd0) begin
                n_phase   = PH_ERR;
                n_esc_cnt = 2'd0;
            end else if (r_phase != PH_DONE && r_phase != PH_ERR) begin
                do_delim = 1'b1;
            end
        end else if (r_phase == PH_PREFIX) begin
            if (!r_tls && r_pos == 4'd4 && i_byte == "s") begin
                n_tls = 1'b1;
                n_pos = 4'd5;
            end else if (pexp != i_byte) begin
                n_phase   = PH_ERR;
                n_esc_cnt = 2'd0;
            end else begin
                n_pos = pos_inc;
                if (pos_inc >= (r_tls ? 4'd8 : 4'd7)) begin
                    n_phase  = PH_A;
                    n_seg    = SEG_FIRST;
                    n_seg_ne = 1'b0;
                end
            end
        end else if (r_phase != PH_DONE && r_phase != PH_ERR) begin
            if (r_esc_cnt == 2'd1) begin
                if (!hx[4]) begin
                    n_phase   = PH_ERR;
                    n_esc_cnt = 2'd0;
                end else begin
                    n_esc_val = hx[3:0];
                    n_esc_cnt = 2'd2;
                end
            end else if (r_esc_cnt == 2'd2) begin
                n_esc_cnt = 2'd0;
                if (!hx[4] || esc_full[7]) begin
                    n_phase = PH_ERR;
                end else begin
                    do_data = 1'b1;
                    dval    = esc_full;
                end
            end else if (i_byte == "%") begin
                n_esc_cnt = 2'd1;
            end else if (is_dl) begin
                do_delim = 1'b1;
            end else begin
                do_data = 1'b1;
            end
        end

        acc_sum = {r_acc, 3'b0} + {2'b0, r_acc, 1'b0} + {16'b0, dval[3:0]};

        if (do_data) begin
            if (r_phase == PH_AFTER) begin
                n_phase   = PH_ERR;
                n_esc_cnt = 2'd0;
            end else begin
                if (r_phase == PH_B || r_phase == PH_PORT) begin
                    if (dval >= "0" && dval <= "9") begin
                        n_acc = (acc_sum > 20'd65535) ? PORT_SAT : acc_sum[16:0];
                        if (!r_seg_ne) n_port_ok = 1'b1;
                    end else begin
                        n_port_ok = 1'b0;
                    end
                end
                n_seg_ne         = 1'b1;
                o_res.char_valid  = 1'b1;
                o_res.char_value  = dval;
                o_res.segment_tag = r_seg;
            end
        end

        if (do_delim) begin
            // per phase: open the next segment, or tail: port check, then vhost, end or error
            unique case (r_phase)
                PH_A: begin
                    if (dval == ":") begin
                        n_flags[RF_HOST]   = r_seg_ne;
                        n_flags[RF_SECOND] = 1'b1;
                        n_phase = PH_B; n_seg = SEG_SECOND; n_seg_ne = 1'b0;
                        n_port_giv = 1'b1; n_acc = '0; n_port_ok = 1'b0;
                    end else if (dval == "@") begin
                        n_flags[RF_USER] = 1'b1;
                        n_phase = PH_H; n_seg = SEG_HOST; n_seg_ne = 1'b0;
                    end else if (dval == "[") begin
                        if (r_seg_ne) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_phase = PH_V6; n_seg = SEG_V6; n_seg_ne = 1'b0;
                        end
                    end else begin
                        n_flags[RF_HOST] = r_seg_ne;
                        if (port_bad) n_phase = PH_ERR;
                        else if (dval == "/") begin
                            n_flags[RF_VHOST] = 1'b1;
                            n_phase = PH_VHOST; n_seg = SEG_VHOST; n_seg_ne = 1'b0;
                        end else if (dval == 8'h00) n_phase = PH_DONE;
                        else n_phase = PH_ERR;
                    end
                end
                PH_B: begin
                    if (dval == "@") begin
                        n_flags[RF_USER] = 1'b1;
                        n_flags[RF_HOST] = 1'b0;
                        n_port_giv = 1'b0;
                        n_phase = PH_H; n_seg = SEG_HOST; n_seg_ne = 1'b0;
                    end else if (dval == ":") begin
                        n_phase = PH_PORT; n_seg = SEG_PORT; n_seg_ne = 1'b0;
                        n_port_giv = 1'b1; n_acc = '0; n_port_ok = 1'b0;
                    end else if (dval == "[") begin
                        n_phase = PH_ERR;
                    end else begin
                        if (port_bad) n_phase = PH_ERR;
                        else if (dval == "/") begin
                            n_flags[RF_VHOST] = 1'b1;
                            n_phase = PH_VHOST; n_seg = SEG_VHOST; n_seg_ne = 1'b0;
                        end else if (dval == 8'h00) n_phase = PH_DONE;
                        else n_phase = PH_ERR;
                    end
                end
                PH_H: begin
                    if (dval == ":") begin
                        n_flags[RF_HOST] = r_seg_ne;
                        n_phase = PH_PORT; n_seg = SEG_PORT; n_seg_ne = 1'b0;
                        n_port_giv = 1'b1; n_acc = '0; n_port_ok = 1'b0;
                    end else if (dval == "[") begin
                        if (r_seg_ne) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_phase = PH_V6; n_seg = SEG_V6; n_seg_ne = 1'b0;
                        end
                    end else begin
                        n_flags[RF_HOST] = r_seg_ne;
                        if (port_bad) n_phase = PH_ERR;
                        else if (dval == "/") begin
                            n_flags[RF_VHOST] = 1'b1;
                            n_phase = PH_VHOST; n_seg = SEG_VHOST; n_seg_ne = 1'b0;
                        end else if (dval == 8'h00) n_phase = PH_DONE;
                        else n_phase = PH_ERR;
                    end
                end
                PH_V6: begin
                    if (dval == "]") begin
                        n_flags[RF_HOST] = 1'b1;
                        n_phase = PH_AFTER; n_seg = SEG_V6; n_seg_ne = 1'b0;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_AFTER: begin
                    if (dval == ":") begin
                        n_phase = PH_PORT; n_seg = SEG_PORT; n_seg_ne = 1'b0;
                        n_port_giv = 1'b1; n_acc = '0; n_port_ok = 1'b0;
                    end else if (port_bad) n_phase = PH_ERR;
                    else if (dval == "/") begin
                        n_flags[RF_VHOST] = 1'b1;
                        n_phase = PH_VHOST; n_seg = SEG_VHOST; n_seg_ne = 1'b0;
                    end else if (dval == 8'h00) n_phase = PH_DONE;
                    else n_phase = PH_ERR;
                end
                PH_PORT: begin
                    if (port_bad) n_phase = PH_ERR;
                    else if (dval == "/") begin
                        n_flags[RF_VHOST] = 1'b1;
                        n_phase = PH_VHOST; n_seg = SEG_VHOST; n_seg_ne = 1'b0;
                    end else if (dval == 8'h00) n_phase = PH_DONE;
                    else n_phase = PH_ERR;
                end
                PH_VHOST: begin
                    if (dval == 8'h00) n_phase = PH_DONE;
                    else n_phase = PH_ERR;
                end
                default: begin
                end
            endcase
            if (n_phase == PH_ERR) n_esc_cnt = 2'd0;
        end

        if (i_end) begin
            o_res.done_res = 1'b1;
            if (n_phase == PH_DONE) begin
                o_res.port_number    = n_port_giv ? n_acc[15:0]
                                     : (n_tls ? i_tls_port : i_plain_port);
                o_res.tls_scheme     = n_tls;
                o_res.first_is_user  = n_flags[RF_USER];
                o_res.second_present = n_flags[RF_SECOND];
                o_res.host_given     = n_flags[RF_HOST];
                o_res.vhost_given    = n_flags[RF_VHOST];
            end else begin
                o_res.status = 1'b1;
            end
            n_phase    = PH_PREFIX;
            n_pos      = '0;
            n_tls      = 1'b0;
            n_esc_cnt  = '0;
            n_esc_val  = '0;
            n_seg      = SEG_FIRST;
            n_seg_ne   = 1'b0;
            n_acc      = '0;
            n_port_ok  = 1'b0;
            n_port_giv = 1'b0;
            n_flags    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_PREFIX;
            r_pos      <= '0;
            r_tls      <= 1'b0;
            r_esc_cnt  <= '0;
            r_esc_val  <= '0;
            r_seg      <= SEG_FIRST;
            r_seg_ne   <= 1'b0;
            r_acc      <= '0;
            r_port_ok  <= 1'b0;
            r_port_giv <= 1'b0;
            r_flags    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_tls      <= n_tls;
            r_esc_cnt  <= n_esc_cnt;
            r_esc_val  <= n_esc_val;
            r_seg      <= n_seg;
            r_seg_ne   <= n_seg_ne;
            r_acc      <= n_acc;
            r_port_ok  <= n_port_ok;
            r_port_giv <= n_port_giv;
            r_flags    <= n_flags;
        end
    end

endmodule

// ===== sv/amqp_url_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// amqp_url_stream_parser_top
// Streams an AMQP URL in one byte per item and streams out one result per
// item: decoded component bytes with segment tags, and the verdict on the
// end item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: s_tdata carries the URL byte, s_tlast marks the terminator
//   item (its byte is ignored). Every accepted item yields exactly one item
//   on the master side, in order.
//   Master side: m_tuser is char_valid; m_tlast is done_res and carries the
//   status, port, TLS and resolution flags in m_tdata.
//   Config: i_cfg_we writes the default plain (index 0) or TLS (index 1)
//   port; write only while the block is idle.
//   Path: the input register takes the item, then the parse step loads
//   the result register from it once that register is free.
//   Throughput: one item per cycle while m_tready stays high; the parse
//   state loop updates on every step, so consecutive bytes never wait
//   on each other.
//   Reset: parse state returns to prefix matching, default ports to 5672
//   and 5671, both pipeline registers are emptied.
//   Stall: the result register holds while m_tready is low; one more item
//   is taken into the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module amqp_url_stream_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // [7:0] url_byte
    input  logic                          i_s_tlast,  // end_of_url
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] char_value, [10:8] segment_tag, [11] status, [27:12] port_number,
    // [28] tls_scheme, [29] first_is_user, [30] second_present,
    // [31] host_given, [32] vhost_given, [39:33] zero
    output logic [amqpu_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                          o_m_tuser,  // char_valid
    output logic                          o_m_tlast,  // done_res
    input  logic                          i_cfg_we,
    input  logic [amqpu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [amqpu_pkg::PORT_W-1:0]  i_cfg_wdata
);
    import amqpu_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;
    logic              r_out_valid;
    t_result           r_out_res;
    t_result           core_res;
    logic [PORT_W-1:0] r_plain_port;
    logic [PORT_W-1:0] r_tls_port;
    logic              step;

    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_end  <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plain_port <= PLAIN_PORT_RST;
            r_tls_port   <= TLS_PORT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PLAIN_PORT: r_plain_port <= i_cfg_wdata;
                CFG_TLS_PORT:   r_tls_port   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    amqpu_parse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_end        (r_in_end),
        .i_plain_port (r_plain_port),
        .i_tls_port   (r_tls_port),
        .o_res        (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_res.char_valid;
    assign o_m_tlast  = r_out_res.done_res;
    assign o_m_tdata  = {7'b0,
                         r_out_res.vhost_given,
                         r_out_res.host_given,
                         r_out_res.second_present,
                         r_out_res.first_is_user,
                         r_out_res.tls_scheme,
                         r_out_res.port_number,
                         r_out_res.status,
                         r_out_res.segment_tag,
                         r_out_res.char_value};

endmodule

// ===== bench/amqp_url_stream_parser_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// amqp_url_stream_parser_top_tb
// Drives AMQP URLs into the parser one byte per item and checks every
// result item against a parser model kept in the bench. The URLs are mostly
// well-formed with random components, escapes and ports, plus broken and
// noisy ones. Default ports are changed between phases. Both stream sides
// idle at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module amqp_url_stream_parser_top_tb;
    import amqpu_pkg::*;

    typedef enum logic [3:0] {
        PH_SCHEME, PH_SEG0, PH_SEG1, PH_HOST, PH_V6, PH_V6_CLOSED,
        PH_PORT, PH_VHOST, PH_DONE, PH_BAD
    } t_parse_phase;

    localparam bit [2:0] SEG_FIRST  = 3'd0;
    localparam bit [2:0] SEG_SECOND = 3'd1;
    localparam bit [2:0] SEG_HOST   = 3'd2;
    localparam bit [2:0] SEG_V6     = 3'd3;
    localparam bit [2:0] SEG_PORT   = 3'd4;
    localparam bit [2:0] SEG_VHOST  = 3'd5;

    localparam bit [7:0] CH_NUL     = 8'h00;
    localparam bit [7:0] CH_COLON   = ":";
    localparam bit [7:0] CH_AT      = "@";
    localparam bit [7:0] CH_SLASH   = "/";
    localparam bit [7:0] CH_LBRACK  = "[";
    localparam bit [7:0] CH_RBRACK  = "]";
    localparam bit [7:0] CH_PERCENT = "%";
    localparam bit [7:0] CH_QUERY   = "?";
    localparam bit [7:0] CH_HASH    = "#";

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata   = '0;   // [7:0] url_byte
    logic                 i_s_tlast   = 1'b0; // end_of_url
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    // [7:0] char_value, [10:8] segment_tag, [11] status, [27:12] port_number,
    // [28] tls_scheme, [29] first_is_user, [30] second_present,
    // [31] host_given, [32] vhost_given, [39:33] zero
    logic [TDATA_W-1:0]   o_m_tdata;
    logic                 o_m_tuser;          // char_valid
    logic                 o_m_tlast;          // done_res
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PORT_W-1:0]    i_cfg_wdata = '0;

    amqp_url_stream_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // parser model state
    bit [PORT_W-1:0] cfg_plain_port;
    bit [PORT_W-1:0] cfg_tls_port;
    t_parse_phase    ph;
    bit [3:0]        pfx_pos;
    bit              tls_seen;
    bit [1:0]        esc_cnt;
    bit [3:0]        esc_hi;
    bit [2:0]        seg_id;
    bit              seg_has_data;
    bit [16:0]       port_acc;
    bit              port_digits_ok;
    bit              port_in_force;
    bit              is_user, has_second, has_host, has_vhost;
    bit              bad_url;
    t_result         step_res;

    bit [7:0] scheme_plain [0:6] = '{"a", "m", "q", "p", ":", "/", "/"};
    bit [7:0] scheme_tls   [0:7] = '{"a", "m", "q", "p", "s", ":", "/", "/"};

    t_result  url_results_due[$];
    t_result  due_res;
    bit [7:0] url_q[$];
    int       items_in;
    int       items_out;
    int       mismatches;
    bit       tx_gaps_on;
    bit       rx_stalls_on;
    int       long_hold_reqs;
    int       long_hold_done;
    int       rx_hold;

    function automatic void reset_parse();
        ph = PH_SCHEME;
        pfx_pos = '0;
        tls_seen = 1'b0;
        esc_cnt = '0;
        esc_hi = '0;
        seg_id = SEG_FIRST;
        seg_has_data = 1'b0;
        port_acc = '0;
        port_digits_ok = 1'b0;
        port_in_force = 1'b0;
        is_user = 1'b0;
        has_second = 1'b0;
        has_host = 1'b0;
        has_vhost = 1'b0;
        bad_url = 1'b0;
    endfunction

    function automatic void mark_bad();
        bad_url = 1'b1;
        ph = PH_BAD;
        esc_cnt = '0;
    endfunction

    function automatic void open_seg(t_parse_phase p, bit [2:0] tag);
        ph = p;
        seg_id = tag;
        seg_has_data = 1'b0;
    endfunction

    function automatic void open_port_seg(t_parse_phase p, bit [2:0] tag);
        open_seg(p, tag);
        port_in_force = 1'b1;
        port_acc = '0;
        port_digits_ok = 1'b0;
    endfunction

    function automatic void close_tail(bit [7:0] d);
        if (port_in_force && !(port_digits_ok && port_acc <= 17'd65535)) begin
            mark_bad();
        end else if (d == CH_SLASH) begin
            has_vhost = 1'b1;
            open_seg(PH_VHOST, SEG_VHOST);
        end else if (d == CH_NUL) begin
            ph = PH_DONE;
        end else begin
            mark_bad();
        end
    endfunction

    function automatic void take_delim(bit [7:0] d);
        case (ph)
            PH_SEG0: begin
                if (d == CH_COLON) begin
                    has_host = seg_has_data;
                    has_second = 1'b1;
                    open_port_seg(PH_SEG1, SEG_SECOND);
                end else if (d == CH_AT) begin
                    is_user = 1'b1;
                    open_seg(PH_HOST, SEG_HOST);
                end else if (d == CH_LBRACK) begin
                    if (seg_has_data) mark_bad();
                    else open_seg(PH_V6, SEG_V6);
                end else begin
                    has_host = seg_has_data;
                    close_tail(d);
                end
            end
            PH_SEG1: begin
                if (d == CH_AT) begin
                    is_user = 1'b1;
                    has_host = 1'b0;
                    port_in_force = 1'b0;
                    open_seg(PH_HOST, SEG_HOST);
                end else if (d == CH_COLON) begin
                    open_port_seg(PH_PORT, SEG_PORT);
                end else if (d == CH_LBRACK) begin
                    mark_bad();
                end else begin
                    close_tail(d);
                end
            end
            PH_HOST: begin
                if (d == CH_COLON) begin
                    has_host = seg_has_data;
                    open_port_seg(PH_PORT, SEG_PORT);
                end else if (d == CH_LBRACK) begin
                    if (seg_has_data) mark_bad();
                    else open_seg(PH_V6, SEG_V6);
                end else begin
                    has_host = seg_has_data;
                    close_tail(d);
                end
            end
            PH_V6: begin
                if (d == CH_RBRACK) begin
                    has_host = 1'b1;
                    open_seg(PH_V6_CLOSED, SEG_V6);
                end else begin
                    mark_bad();
                end
            end
            PH_V6_CLOSED: begin
                if (d == CH_COLON) open_port_seg(PH_PORT, SEG_PORT);
                else close_tail(d);
            end
            PH_PORT: close_tail(d);
            PH_VHOST: begin
                if (d == CH_NUL) ph = PH_DONE;
                else mark_bad();
            end
            default: ;
        endcase
    endfunction

    function automatic void take_char(bit [7:0] v);
        int unsigned acc;
        if (ph == PH_V6_CLOSED) begin
            mark_bad();
            return;
        end
        if (ph == PH_SEG1 || ph == PH_PORT) begin
            if (v >= "0" && v <= "9") begin
                acc = port_acc * 10 + (v - "0");
                port_acc = (acc > 65535) ? 17'd65536 : acc[16:0];
                if (!seg_has_data) port_digits_ok = 1'b1;
            end else begin
                port_digits_ok = 1'b0;
            end
        end
        seg_has_data = 1'b1;
        step_res.char_valid = 1'b1;
        step_res.char_value = v;
        step_res.segment_tag = seg_id;
    endfunction

    function automatic int hex_digit(bit [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic t_result parse_url_byte(bit [7:0] b, bit last);
        int       h;
        bit [7:0] want_ch;
        bit [7:0] v;
        step_res = '0;
        if (last) begin
            if (ph == PH_SCHEME || esc_cnt != 0) mark_bad();
            else if (ph != PH_DONE && ph != PH_BAD) take_delim(CH_NUL);
            step_res.done_res = 1'b1;
            if (ph == PH_DONE && !bad_url) begin
                step_res.port_number = port_in_force ? port_acc[15:0] :
                                       (tls_seen ? cfg_tls_port : cfg_plain_port);
                step_res.tls_scheme = tls_seen;
                step_res.first_is_user = is_user;
                step_res.second_present = has_second;
                step_res.host_given = has_host;
                step_res.vhost_given = has_vhost;
            end else begin
                step_res.status = 1'b1;
            end
            reset_parse();
        end else if (ph == PH_SCHEME) begin
            if (!tls_seen && pfx_pos == 4 && b == "s") begin
                tls_seen = 1'b1;
                pfx_pos = 4'd5;
            end else begin
                want_ch = tls_seen ? scheme_tls[pfx_pos[2:0]] : scheme_plain[pfx_pos[2:0]];
                if (want_ch != b) mark_bad();
                else pfx_pos++;
            end
            if (ph == PH_SCHEME && pfx_pos >= (tls_seen ? 8 : 7)) open_seg(PH_SEG0, SEG_FIRST);
        end else if (ph != PH_DONE && ph != PH_BAD) begin
            if (esc_cnt == 2'd1) begin
                h = hex_digit(b);
                if (h < 0) begin
                    mark_bad();
                end else begin
                    esc_hi = h[3:0];
                    esc_cnt = 2'd2;
                end
            end else if (esc_cnt == 2'd2) begin
                h = hex_digit(b);
                if (h < 0) begin
                    mark_bad();
                end else begin
                    v = {esc_hi, h[3:0]};
                    esc_cnt = '0;
                    if (v > 8'h7F) mark_bad();
                    else take_char(v);
                end
            end else if (b == CH_PERCENT) begin
                esc_cnt = 2'd1;
            end else if (b == CH_NUL || b == CH_SLASH || b == CH_QUERY || b == CH_HASH ||
                         b == CH_LBRACK || b == CH_RBRACK ||
                         (ph != PH_V6 && (b == CH_COLON || b == CH_AT))) begin
                take_delim(b);
            end else begin
                take_char(b);
            end
        end
        return step_res;
    endfunction

    // input side: every accepted item gets its expected result
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            url_results_due.push_back(parse_url_byte(i_s_tdata, i_s_tlast));
    end

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            items_out++;
            if (url_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h tuser %b tlast %b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
                mismatches++;
            end else begin
                due_res = url_results_due.pop_front();
                compare_field("char_valid", 32'(due_res.char_valid), 32'(o_m_tuser));
                compare_field("char_value", 32'(due_res.char_value), 32'(o_m_tdata[7:0]));
                compare_field("segment_tag", 32'(due_res.segment_tag),
                              32'(o_m_tdata[10:8]));
                compare_field("done_res", 32'(due_res.done_res), 32'(o_m_tlast));
                compare_field("status", 32'(due_res.status), 32'(o_m_tdata[11]));
                compare_field("port_number", 32'(due_res.port_number),
                              32'(o_m_tdata[27:12]));
                compare_field("tls_scheme", 32'(due_res.tls_scheme), 32'(o_m_tdata[28]));
                compare_field("first_is_user", 32'(due_res.first_is_user),
                              32'(o_m_tdata[29]));
                compare_field("second_present", 32'(due_res.second_present),
                              32'(o_m_tdata[30]));
                compare_field("host_given", 32'(due_res.host_given), 32'(o_m_tdata[31]));
                compare_field("vhost_given", 32'(due_res.vhost_given), 32'(o_m_tdata[32]));
                compare_field("tdata padding", 0, 32'(o_m_tdata[TDATA_W-1:33]));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (long_hold_reqs != long_hold_done) begin
            long_hold_done = long_hold_reqs;
            rx_hold = 300;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
            rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic send_item(bit [7:0] b, bit last);
        int gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 99) < 25)
            gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        items_in++;
    endtask

    task automatic send_url();
        foreach (url_q[i]) send_item(url_q[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        while (items_out != items_in) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_default_ports(bit [PORT_W-1:0] plain_port, bit [PORT_W-1:0] tls_port);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PLAIN_PORT;
        i_cfg_wdata <= plain_port;
        @(posedge i_clk);
        i_cfg_index <= CFG_TLS_PORT;
        i_cfg_wdata <= tls_port;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_plain_port = plain_port;
        cfg_tls_port = tls_port;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) url_q.push_back(s[i]);
    endtask

    function automatic bit [7:0] hex_char(bit [3:0] n, bit upper);
        if (n < 10) return "0" + n;
        return 8'((upper ? "A" : "a") + n - 10);
    endfunction

    task automatic add_escape(bit [7:0] v);
        bit upper;
        upper = 1'($urandom_range(0, 1));
        url_q.push_back(CH_PERCENT);
        url_q.push_back(hex_char(v[7:4], upper));
        url_q.push_back(hex_char(v[3:0], upper));
    endtask

    task automatic add_component(int n, bit in_brackets);
        string pool;
        int    r;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~";
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (in_brackets && r < 30) begin
                url_q.push_back(($urandom_range(0, 3) == 0) ? CH_AT : CH_COLON);
            end else if (r < 75) begin
                url_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            end else if (r < 92) begin
                add_escape(8'($urandom_range(0, 127)));
            end else if (r < 95) begin
                case ($urandom_range(0, 2))
                    0: add_escape(8'($urandom_range(128, 255)));
                    1: add_text("%g1");
                    default: add_text("%4z");
                endcase
            end else begin
                url_q.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    task automatic add_port_text();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) add_text($sformatf("%0d", $urandom_range(0, 65535)));
        else if (r < 65) begin
            if ($urandom_range(0, 1) == 1) add_text("65535");
            else add_text("65536");
        end
        else if (r < 75) add_text($sformatf("%0d", $urandom_range(65537, 9999999)));
        else if (r < 80) add_text("000080");
        else if (r < 90) ;
        else add_component($urandom_range(1, 3), 1'b0);
    endtask

    task automatic add_host();
        if ($urandom_range(0, 4) == 0) begin
            url_q.push_back(CH_LBRACK);
            add_component($urandom_range(0, 8), 1'b1);
            url_q.push_back(CH_RBRACK);
        end else begin
            add_component($urandom_range(0, 8), 1'b0);
        end
        if ($urandom_range(0, 1) == 1) begin
            url_q.push_back(CH_COLON);
            add_port_text();
        end
    endtask

    task automatic build_url();
        int idx;
        url_q.delete();
        if ($urandom_range(0, 1) == 1) add_text("amqps://");
        else add_text("amqp://");
        case ($urandom_range(0, 4))
            0: add_host();
            1: begin
                add_component($urandom_range(0, 6), 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    url_q.push_back(CH_COLON);
                    add_component($urandom_range(0, 6), 1'b0);
                end
                url_q.push_back(CH_AT);
                add_host();
            end
            2: begin
                add_component($urandom_range(0, 6), 1'b0);
                url_q.push_back(CH_COLON);
                add_port_text();
            end
            3: begin
                add_component($urandom_range(0, 6), 1'b0);
                url_q.push_back(CH_COLON);
                add_port_text();
                url_q.push_back(CH_COLON);
                add_port_text();
            end
            default: begin
                url_q.push_back(CH_LBRACK);
                add_component($urandom_range(0, 10), 1'b1);
                url_q.push_back(CH_RBRACK);
                if ($urandom_range(0, 1) == 1) begin
                    url_q.push_back(CH_COLON);
                    add_port_text();
                end
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            url_q.push_back(CH_SLASH);
            add_component($urandom_range(0, 6), 1'b0);
        end
        if ($urandom_range(0, 9) == 0) begin
            // raw NUL ends the URL early; trailing bytes are ignored
            url_q.push_back(CH_NUL);
            repeat ($urandom_range(0, 3)) url_q.push_back(8'($urandom_range(0, 255)));
        end
        // broken URLs
        if ($urandom_range(0, 4) == 0) begin
            idx = $urandom_range(0, url_q.size() - 1);
            case ($urandom_range(0, 3))
                0: url_q[idx] = 8'($urandom_range(0, 255));
                1: while (url_q.size() > idx) void'(url_q.pop_back());
                2: url_q.insert(idx, 8'($urandom_range(0, 255)));
                default: begin
                    url_q.delete();
                    repeat ($urandom_range(0, 12)) url_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    task automatic run_random_urls(int n_items);
        int target;
        target = items_in + n_items;
        while (items_in < target) begin
            build_url();
            send_url();
            if ($urandom_range(0, 11) == 0) wait_results_drained();
        end
    endtask

    task automatic test_directed_urls();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        url_q.delete();
        add_text("amqp://%7F:0");
        send_url();
        url_q.delete();
        add_text("amqps://%00@[]");
        url_q.push_back(CH_NUL);
        url_q.push_back(8'hFF);
        foreach (url_q[i]) send_item(url_q[i], 1'b0);
        send_item(8'hFF, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_port_register_extremes();
        write_default_ports(16'd0, 16'hFFFF);
        run_random_urls(350);
        wait_results_drained();
        write_default_ports(16'hFFFF, 16'd0);
        run_random_urls(350);
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        long_hold_reqs++;
        run_random_urls(60);
        wait_results_drained();
    endtask

    task automatic test_full_rate_stream();
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        run_random_urls(250);
        wait_results_drained();
    endtask

    task automatic test_random_defaults();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        write_default_ports(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_random_urls(400);
        wait_results_drained();
    endtask

    initial begin
        reset_parse();
        cfg_plain_port = PLAIN_PORT_RST;
        cfg_tls_port = TLS_PORT_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_urls();
        test_port_register_extremes();
        test_output_backpressure();
        test_full_rate_stream();
        test_random_defaults();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && url_results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
